// File: hdl/srsc_pkg.sv
// Shared types and constants for the shadow return stack checker.
`timescale 1ns / 1ps

package srsc_pkg;

  // Default configuration
  localparam int STACK_DEPTH_DEF  = 64;
  localparam int ADDRESS_BITS_DEF = 48;

  // Event kinds carried on the input tuser bit
  localparam logic ACT_ENTRY = 1'b0;
  localparam logic ACT_EXIT  = 1'b1;

  // Result codes carried on the output tuser
  typedef enum logic [2:0] {
    ST_PUSHED    = 3'd0,
    ST_MATCH     = 3'd1,
    ST_MISMATCH  = 3'd2,
    ST_OVERFLOW  = 3'd3,
    ST_UNDERFLOW = 3'd4,
    ST_HALTED    = 3'd5
  } status_t;

  // Control from the checker to the stack store
  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } stack_ctl_t;

endpackage

// File: hdl/shadow_return_stack_checker.sv
// Top level: event decode, depth and halt tracking, and the result register.
`timescale 1ns / 1ps

// Shadow return-address stack. Each input transaction is a function entry
// (tuser 0, push) or exit (tuser 1, pop and compare) with its call-site address
// in tdata. Every transaction yields exactly one result in the cycle after it is
// accepted, and a new transaction is taken every cycle while the result side
// keeps up: the current top entry always sits in a register fed by a single
// registered memory read at the next depth, forwarded from the write port when
// a push lands on it. A return mismatch sets a sticky halt that only reset
// clears; while halted every transaction answers with the halted code. A push
// onto a full stack reports overflow and drops the address; a pop from an empty
// stack reports underflow. The stack memory needs no clearing after reset.

module shadow_return_stack_checker
  import srsc_pkg::*;
#(
  parameter int STACK_DEPTH  = STACK_DEPTH_DEF,
  parameter int ADDRESS_BITS = ADDRESS_BITS_DEF,
  localparam int AW    = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1,
  localparam int CW    = $clog2(STACK_DEPTH + 1),
  localparam int IN_W  = ((ADDRESS_BITS + 7) / 8) * 8,
  localparam int OUT_W = ((ADDRESS_BITS + CW + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [IN_W-1:0]  s_tdata,   // site_address
  input  logic [0:0]       s_tuser,   // action
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [OUT_W-1:0] m_tdata,   // stored_address, stack_depth
  output logic [2:0]       m_tuser    // status
);

  logic [CW-1:0]           depth, depth_next;
  logic                    halted, halted_next;
  logic [ADDRESS_BITS-1:0] top;
  logic [ADDRESS_BITS-1:0] site;
  logic [CW-1:0]           rd_full;
  logic [AW-1:0]           rd_addr;
  logic                    accept;
  stack_ctl_t              ctl;
  status_t                 status_c, status_q;
  logic [ADDRESS_BITS-1:0] addr_c, addr_q;
  logic [CW-1:0]           depth_q;

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;
  assign site     = s_tdata[ADDRESS_BITS-1:0];

  // Decode the event against the current depth and top entry
  always_comb begin
    status_c    = ST_HALTED;
    addr_c      = '0;
    depth_next  = depth;
    halted_next = halted;
    ctl.wr_en   = 1'b0;
    if (halted) begin
      status_c = ST_HALTED;
    end else if (s_tuser[0] == ACT_ENTRY) begin
      if (depth == CW'(STACK_DEPTH)) begin
        status_c = ST_OVERFLOW;
      end else begin
        status_c   = ST_PUSHED;
        ctl.wr_en  = accept;
        depth_next = depth + CW'(1);
      end
    end else if (depth == '0) begin
      status_c = ST_UNDERFLOW;
    end else begin
      depth_next = depth - CW'(1);
      addr_c     = top;
      if (top == site) begin
        status_c = ST_MATCH;
      end else begin
        status_c    = ST_MISMATCH;
        halted_next = 1'b1;
      end
    end
    rd_full    = depth_next - CW'(1);
    ctl.rd_en  = accept && (depth_next != '0);
  end

  assign rd_addr = rd_full[AW-1:0];

  srsc_stack #(
    .STACK_DEPTH  (STACK_DEPTH),
    .ADDRESS_BITS (ADDRESS_BITS)
  ) u_stack (
    .clk     (clk),
    .ctl     (ctl),
    .wr_addr (depth[AW-1:0]),
    .wr_data (site),
    .rd_addr (rd_addr),
    .top     (top)
  );

  // Advance depth and halt state on each accepted transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      depth  <= '0;
      halted <= 1'b0;
    end else if (accept) begin
      depth  <= depth_next;
      halted <= halted_next;
    end
  end

  // Hold the result until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status_q <= status_c;
      addr_q   <= addr_c;
      depth_q  <= depth_next;
    end
  end

  assign m_tuser = status_q;
  assign m_tdata = OUT_W'({depth_q, addr_q});

  // A mismatch leaves the block halted
  a_mismatch_halts : assert property (@(posedge clk) disable iff (rst)
    accept && !halted && (status_c == ST_MISMATCH) |=> halted)
    else $error("mismatch did not set halt");

  // Depth never passes the stack size
  a_depth_bound : assert property (@(posedge clk) disable iff (rst)
    depth <= CW'(STACK_DEPTH))
    else $error("stack depth out of range");

  // Once halted the stack stays frozen
  a_halt_freezes : assert property (@(posedge clk) disable iff (rst)
    halted |=> halted && $stable(depth))
    else $error("stack changed while halted");

  // A pushed result always reports a non-empty stack
  a_push_depth : assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (status_q == ST_PUSHED) |-> (depth_q != '0))
    else $error("push reported an empty stack");

endmodule

// File: hdl/srsc_stack.sv
// Stack store: address memory with a registered top-of-stack read and write forwarding.
`timescale 1ns / 1ps

module srsc_stack
  import srsc_pkg::*;
#(
  parameter int STACK_DEPTH  = STACK_DEPTH_DEF,
  parameter int ADDRESS_BITS = ADDRESS_BITS_DEF,
  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1
) (
  input  logic                    clk,
  input  stack_ctl_t              ctl,
  input  logic [AW-1:0]           wr_addr,
  input  logic [ADDRESS_BITS-1:0] wr_data,
  input  logic [AW-1:0]           rd_addr,
  output logic [ADDRESS_BITS-1:0] top
);

  logic [ADDRESS_BITS-1:0] mem [STACK_DEPTH];

  // Write the pushed address
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Fetch the new top entry, taking the address written in this cycle if it lands there
  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      if (ctl.wr_en && (wr_addr == rd_addr)) begin
        top <= wr_data;
      end else begin
        top <= mem[rd_addr];
      end
    end
  end

endmodule

// File: tb/shadow_return_stack_checker_tb.sv
// Self-checking testbench for the shadow return stack checker.
`timescale 1ns / 1ps

module shadow_return_stack_checker_tb;
  import srsc_pkg::*;

  localparam int DEPTH         = STACK_DEPTH_DEF;
  localparam int ABITS         = ADDRESS_BITS_DEF;
  localparam int CW            = $clog2(DEPTH + 1);
  localparam int IN_W          = ((ABITS + 7) / 8) * 8;
  localparam int OUT_W         = ((ABITS + CW + 7) / 8) * 8;
  localparam int IDLE_PCT      = 32;
  localparam int IDLE_LIMIT    = 3000;
  localparam int HOLD_CYCLES   = 200;
  localparam int RANDOM_EVENTS = 400;

  typedef logic [ABITS-1:0] site_t;

  typedef struct packed {
    status_t       status;
    site_t         addr;
    logic [CW-1:0] depth;
  } outcome_t;

  logic             clk      = 1'b0;
  logic             rst      = 1'b1;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [IN_W-1:0]  s_tdata  = '0;  // site_address
  logic [0:0]       s_tuser  = '0;  // action
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;        // stored_address, stack_depth
  logic [2:0]       m_tuser;        // status

  // Shadow copy of the call stack, updated on each accepted transaction
  site_t    shadow_store [DEPTH];
  int       shadow_depth  = 0;
  bit       shadow_halted = 1'b0;
  outcome_t expected_results [$];

  int errors        = 0;
  int hold_requests = 0;
  bit steady        = 1'b0;

  shadow_return_stack_checker uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #4 clk = ~clk;

  // Work out the result of one accepted event and advance the shadow stack
  function automatic void predict_event(logic act, site_t site);
    outcome_t o;
    o.addr = '0;
    if (shadow_halted) begin
      o.status = ST_HALTED;
    end else if (act == ACT_ENTRY) begin
      if (shadow_depth >= DEPTH) begin
        o.status = ST_OVERFLOW;
      end else begin
        shadow_store[shadow_depth] = site;
        shadow_depth++;
        o.status = ST_PUSHED;
      end
    end else if (shadow_depth == 0) begin
      o.status = ST_UNDERFLOW;
    end else begin
      shadow_depth--;
      o.addr = shadow_store[shadow_depth];
      if (o.addr == site) begin
        o.status = ST_MATCH;
      end else begin
        o.status = ST_MISMATCH;
        shadow_halted = 1'b1;
      end
    end
    o.depth = CW'(shadow_depth);
    expected_results.push_back(o);
  endfunction

  function automatic site_t stack_top();
    return shadow_store[shadow_depth - 1];
  endfunction

  // Mostly full-width random addresses, with the extremes now and then
  function automatic site_t random_site();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      default: return site_t'({$urandom(), $urandom()});
    endcase
  endfunction

  // Offer one event and hold it until the transaction completes
  task automatic send_event(input logic act, input site_t site);
    s_tvalid <= 1'b1;
    s_tuser  <= act;
    s_tdata  <= IN_W'(site);
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_event(act, site);
    if (!steady && $urandom_range(99) < IDLE_PCT) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
  endtask

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endfunction

  // Check each result transaction and drive the result-side ready
  initial begin : result_side
    int       hold_left;
    int       holds_granted;
    outcome_t want;
    hold_left     = 0;
    holds_granted = 0;
    forever begin
      @(posedge clk);
      if (m_tvalid && m_tready) begin
        if (expected_results.size() == 0) begin
          $error("result with nothing expected: status %0d tdata %0h", m_tuser, m_tdata);
          errors++;
        end else begin
          want = expected_results.pop_front();
          check_field("status", 64'(want.status), 64'(m_tuser));
          check_field("stored_address", 64'(want.addr), 64'(m_tdata[ABITS-1:0]));
          check_field("stack_depth", 64'(want.depth), 64'(m_tdata[ABITS +: CW]));
        end
      end
      if (hold_left == 0 && holds_granted < hold_requests) begin
        holds_granted++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // Give up when nothing moves for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
      else quiet++;
      if (quiet >= IDLE_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // Extreme addresses, matched returns and underflow on an empty stack
  task automatic test_push_pop_extremes();
    send_event(ACT_ENTRY, '0);
    send_event(ACT_ENTRY, '1);
    send_event(ACT_EXIT, '1);
    send_event(ACT_EXIT, '0);
    send_event(ACT_EXIT, '1);
    send_event(ACT_EXIT, '0);
    send_event(ACT_ENTRY, site_t'(48'hAAAA_AAAA_AAAA));
    send_event(ACT_ENTRY, site_t'(48'h5555_5555_5555));
    send_event(ACT_EXIT, site_t'(48'h5555_5555_5555));
    send_event(ACT_EXIT, site_t'(48'hAAAA_AAAA_AAAA));
  endtask

  // Fill the stack, push past the top, then drain it below empty
  task automatic test_full_stack();
    repeat (DEPTH) send_event(ACT_ENTRY, random_site());
    repeat (2) send_event(ACT_ENTRY, random_site());
    repeat (DEPTH) send_event(ACT_EXIT, stack_top());
    send_event(ACT_EXIT, random_site());
  endtask

  // Well-formed call/return bursts that drift deep and shallow
  task automatic test_random_traffic();
    int sent;
    int push_pct;
    sent = 0;
    while (sent < RANDOM_EVENTS) begin
      case ($urandom_range(2))
        0: push_pct = 85;
        1: push_pct = 20;
        default: push_pct = 55;
      endcase
      repeat ($urandom_range(60, 10)) begin
        if (sent >= RANDOM_EVENTS) break;
        steady = (sent >= 200 && sent < 300);
        if (sent == 380) hold_requests++;
        if ($urandom_range(99) < push_pct) send_event(ACT_ENTRY, random_site());
        else send_event(ACT_EXIT, (shadow_depth > 0) ? stack_top() : random_site());
        sent++;
      end
    end
    steady = 1'b0;
  endtask

  // Corrupt one return address, then confirm the block stays halted
  task automatic test_mismatch_halt();
    repeat (3) send_event(ACT_ENTRY, random_site());
    send_event(ACT_EXIT, stack_top() ^ (site_t'(1) << $urandom_range(ABITS - 1)));
    repeat (12) send_event(1'($urandom_range(1)), random_site());
  endtask

  initial begin : run
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_push_pop_extremes();
    test_full_stack();
    test_random_traffic();
    test_mismatch_halt();
    s_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
